[hdl/multichannel_compare_timer_macros.svh]
// assertion macros for the compare timer checker
`ifndef MULTICHANNEL_COMPARE_TIMER_MACROS_SVH
`define MULTICHANNEL_COMPARE_TIMER_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define MCT_CHECK_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mct check failed in current cycle");

// next-cycle implication, sampled on clock, off during reset
`define MCT_CHECK_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mct check failed in next cycle");

// state seen in the cycle after reset
`define MCT_CHECK_RESET(label, cons) \
   label: assert property (@(posedge clock) reset |=> (cons)) \
      else $error("mct check failed after reset");

`endif

[hdl/mct_pkg.sv]
package mct_pkg;

   localparam int NUM_SLOTS   = 4;
   localparam int SLOT_W      = 2;
   localparam int WORD_W      = 32;
   localparam int TYPE_W      = 2;
   localparam int INDEX_W     = 4;

   localparam int REQ_TDATA_W = 72;
   localparam int REQ_TUSER_W = TYPE_W;
   localparam int RSP_TDATA_W = 40;
   localparam int RSP_PAD_W   = RSP_TDATA_W - WORD_W - 1;

   localparam logic [TYPE_W-1:0] REQ_READ  = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_WRITE = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_TICK  = 2'd2;

   localparam logic [INDEX_W-1:0] IDX_CONTROL  = 4'd0;
   localparam logic [INDEX_W-1:0] IDX_STATUS   = 4'd1;
   localparam logic [INDEX_W-1:0] IDX_COUNTER0 = 4'd2;
   localparam logic [INDEX_W-1:0] IDX_COMPARE0 = 4'd6;
   localparam logic [INDEX_W-1:0] IDX_SLOTS    = 4'd4;

   localparam int CTL_PRESCALE_LSB = 4;
   localparam int CTL_IRQ_CMP_LSB  = 12;
   localparam int CTL_CLEAR_LSB    = 16;
   localparam int CTL_IRQ_OVF_LSB  = 20;
   localparam int STS_OVF_LSB      = 4;

   localparam logic [1:0] PRESCALE_1  = 2'b00;
   localparam logic [1:0] PRESCALE_4  = 2'b01;
   localparam logic [1:0] PRESCALE_8  = 2'b10;
   localparam logic [1:0] PRESCALE_12 = 2'b11;

   typedef struct packed {
      logic       enable;
      logic [1:0] prescale;
      logic       compare_irq_en;
      logic       clear_on_compare;
      logic       overflow_irq_en;
   } chan_ctl_type;

   typedef struct packed {
      logic set_compare;
      logic set_overflow;
      logic irq;
   } chan_event_type;

endpackage

[hdl/mct_channel.sv]
module mct_channel
   import mct_pkg::*;
(
   input  logic [WORD_W-1:0] tick_count,
   input  chan_ctl_type      ctl,
   input  logic [WORD_W-1:0] counter,
   input  logic [WORD_W-1:0] compare,
   input  logic              compare_flag,
   input  logic              overflow_flag,
   output logic [WORD_W-1:0] counter_next,
   output chan_event_type    events
);

   logic [WORD_W-1:0] inc;
   logic [WORD_W:0]   sum;
   logic              hit;
   logic              wrap;

   // prescale multiply as shift-add
   always_comb begin
      unique case (ctl.prescale)
         PRESCALE_1:  inc = tick_count;
         PRESCALE_4:  inc = tick_count << 2;
         PRESCALE_8:  inc = tick_count << 3;
         PRESCALE_12: inc = (tick_count << 3) + (tick_count << 2);
         default:     inc = tick_count;
      endcase
   end

   assign sum  = {1'b0, counter} + {1'b0, inc};
   assign hit  = (counter < compare) && (sum[WORD_W-1:0] >= compare);
   assign wrap = sum[WORD_W];

   always_comb begin
      counter_next        = counter;
      events.set_compare  = 1'b0;
      events.set_overflow = 1'b0;
      events.irq          = 1'b0;
      if (ctl.enable) begin
         counter_next = sum[WORD_W-1:0];
         if (hit && !compare_flag) begin
            events.set_compare = 1'b1;
            if (ctl.compare_irq_en) begin
               events.irq = 1'b1;
            end
            if (ctl.clear_on_compare) begin
               counter_next = '0;
            end
         end
         if (wrap && !overflow_flag) begin
            events.set_overflow = 1'b1;
            if (ctl.overflow_irq_en) begin
               events.irq = 1'b1;
            end
         end
      end
   end

endmodule

[hdl/multichannel_compare_timer.sv]
// multichannel compare timer
// req channel: one transfer per register read, register write or tick.
//   req_tuser carries the request type (0 read, 1 write, 2 tick, 3 ignored).
// rsp channel: exactly one transfer per request, in request order, carrying
//   the read data (zero unless a word read hits a register) and the irq flag
//   (set only when a tick raised the timer interrupt).
// path: an accepted request is held in the request register, then computed
//   into the response register, whose valid output presents the response.
// throughput: one request per cycle while the response is not stalled; the
//   register file and all channel adders update as a request moves from the
//   request register into the response register.
// stall: while rsp_tready is low the response holds and one more request is
//   taken into the request register; req_tready then drops until the
//   response transfer completes.
// reset: synchronous, clears both registers' valid bits and all timer state
//   (control, status, counters, compares) to zero.
module multichannel_compare_timer
   import mct_pkg::*;
#(
   parameter int CHANNELS = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // reg_index[3:0], word_access[4], write_data[36:5], tick_count[68:37], zeros
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // req_type[1:0]
   input  logic [REQ_TUSER_W-1:0] req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // read_data[31:0], irq_raise[32], zeros
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   logic                in_valid_ff, in_valid_in;
   logic [TYPE_W-1:0]   in_type_ff, in_type_in;
   logic [INDEX_W-1:0]  in_index_ff, in_index_in;
   logic                in_word_ff, in_word_in;
   logic [WORD_W-1:0]   in_wdata_ff, in_wdata_in;
   logic [WORD_W-1:0]   in_count_ff, in_count_in;

   logic                out_valid_ff, out_valid_in;
   logic [WORD_W-1:0]   rdata_ff, rdata_in;
   logic                irq_ff, irq_in;

   logic [WORD_W-1:0]   control_ff, control_in;
   logic [WORD_W-1:0]   status_ff, status_in;
   logic [WORD_W-1:0]   counter_ff [NUM_SLOTS];
   logic [WORD_W-1:0]   counter_in [NUM_SLOTS];
   logic [WORD_W-1:0]   compare_ff [NUM_SLOTS];
   logic [WORD_W-1:0]   compare_in [NUM_SLOTS];

   chan_ctl_type        slot_ctl [NUM_SLOTS];
   chan_event_type      slot_event [NUM_SLOTS];
   logic [WORD_W-1:0]   slot_next [NUM_SLOTS];

   logic                req_transfer;
   logic                fire;
   logic [INDEX_W-1:0]  counter_off;
   logic [INDEX_W-1:0]  compare_off;
   logic [WORD_W-1:0]   read_value;

   assign fire         = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready   = !in_valid_ff || fire;
   assign req_transfer = req_tvalid && req_tready;

   genvar g;
   generate
      for (g = 0; g < NUM_SLOTS; g++) begin : gen_slot
         assign slot_ctl[g].enable           = (g < CHANNELS) ? control_ff[g] : 1'b0;
         assign slot_ctl[g].prescale         = control_ff[CTL_PRESCALE_LSB + 2*g +: 2];
         assign slot_ctl[g].compare_irq_en   = control_ff[CTL_IRQ_CMP_LSB + g];
         assign slot_ctl[g].clear_on_compare = control_ff[CTL_CLEAR_LSB + g];
         assign slot_ctl[g].overflow_irq_en  = control_ff[CTL_IRQ_OVF_LSB + g];

         mct_channel u_channel (
            .tick_count    (in_count_ff),
            .ctl           (slot_ctl[g]),
            .counter       (counter_ff[g]),
            .compare       (compare_ff[g]),
            .compare_flag  (status_ff[g]),
            .overflow_flag (status_ff[STS_OVF_LSB + g]),
            .counter_next  (slot_next[g]),
            .events        (slot_event[g])
         );
      end
   endgenerate

   assign counter_off = in_index_ff - IDX_COUNTER0;
   assign compare_off = in_index_ff - IDX_COMPARE0;

   always_comb begin
      priority if (in_index_ff == IDX_CONTROL) begin
         read_value = control_ff;
      end else if (in_index_ff == IDX_STATUS) begin
         read_value = status_ff;
      end else if (in_index_ff >= IDX_COUNTER0 && in_index_ff < IDX_COUNTER0 + IDX_SLOTS) begin
         read_value = counter_ff[counter_off[SLOT_W-1:0]];
      end else if (in_index_ff >= IDX_COMPARE0 && in_index_ff < IDX_COMPARE0 + IDX_SLOTS) begin
         read_value = compare_ff[compare_off[SLOT_W-1:0]];
      end else begin
         read_value = '0;
      end
   end

   // request register
   always_comb begin
      in_type_in  = in_type_ff;
      in_index_in = in_index_ff;
      in_word_in  = in_word_ff;
      in_wdata_in = in_wdata_ff;
      in_count_in = in_count_ff;
      if (req_transfer) begin
         in_valid_in = 1'b1;
         in_type_in  = req_tuser[TYPE_W-1:0];
         in_index_in = req_tdata[3:0];
         in_word_in  = req_tdata[4];
         in_wdata_in = req_tdata[36:5];
         in_count_in = req_tdata[68:37];
      end else if (fire) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   // register file, channel updates and response register
   always_comb begin
      control_in = control_ff;
      status_in  = status_ff;
      counter_in = counter_ff;
      compare_in = compare_ff;
      rdata_in   = rdata_ff;
      irq_in     = irq_ff;
      if (fire) begin
         out_valid_in = 1'b1;
         rdata_in     = '0;
         irq_in       = 1'b0;
         unique case (in_type_ff)
            REQ_READ: begin
               if (in_word_ff) begin
                  rdata_in = read_value;
               end
            end
            REQ_WRITE: begin
               if (in_word_ff) begin
                  priority if (in_index_ff == IDX_CONTROL) begin
                     control_in = in_wdata_ff;
                  end else if (in_index_ff == IDX_STATUS) begin
                     status_in = in_wdata_ff;
                  end else if (in_index_ff >= IDX_COMPARE0
                               && in_index_ff < IDX_COMPARE0 + IDX_SLOTS) begin
                     compare_in[compare_off[SLOT_W-1:0]] = in_wdata_ff;
                  end else begin
                     control_in = control_ff;
                  end
               end
            end
            REQ_TICK: begin
               for (int i = 0; i < NUM_SLOTS; i++) begin
                  counter_in[i] = slot_next[i];
                  if (slot_event[i].set_compare) begin
                     status_in[i] = 1'b1;
                  end
                  if (slot_event[i].set_overflow) begin
                     status_in[STS_OVF_LSB + i] = 1'b1;
                  end
                  if (slot_event[i].irq) begin
                     irq_in = 1'b1;
                  end
               end
            end
            default: begin
               rdata_in = '0;
            end
         endcase
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         control_ff   <= '0;
         status_ff    <= '0;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            counter_ff[i] <= '0;
            compare_ff[i] <= '0;
         end
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         control_ff   <= control_in;
         status_ff    <= status_in;
         counter_ff   <= counter_in;
         compare_ff   <= compare_in;
      end
      in_type_ff  <= in_type_in;
      in_index_ff <= in_index_in;
      in_word_ff  <= in_word_in;
      in_wdata_ff <= in_wdata_in;
      in_count_ff <= in_count_in;
      rdata_ff    <= rdata_in;
      irq_ff      <= irq_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, irq_ff, rdata_ff};

endmodule

[hdl/mct_checker.sv]
`include "multichannel_compare_timer_macros.svh"

module mct_checker
   import mct_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic [REQ_TUSER_W-1:0] req_tuser,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata
);

   // requests taken but not yet answered
   logic [1:0] pending_ff, pending_in;
   logic       req_transfer;
   logic       rsp_transfer;
   logic       req_seen;

   assign req_transfer = req_tvalid && req_tready;
   assign rsp_transfer = rsp_tvalid && rsp_tready;
   assign req_seen     = (req_tdata != '0) || (req_tuser != '0) || 1'b1;

   always_comb begin
      pending_in = pending_ff;
      if (req_transfer && !rsp_transfer) begin
         pending_in = pending_ff + 2'd1;
      end else if (rsp_transfer && !req_transfer) begin
         pending_in = pending_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   `MCT_CHECK_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `MCT_CHECK_RESET(a_reset_empty, !rsp_tvalid && req_tready)
   `MCT_CHECK_NOW(a_stall_only_on_rsp, !req_tready, rsp_tvalid && !rsp_tready)
   `MCT_CHECK_NOW(a_pending_bound, req_seen, pending_ff != 2'd3 && (!rsp_tvalid || pending_ff != 2'd0))

endmodule

bind multichannel_compare_timer mct_checker u_mct_checker (.*);
